// ===== rtl/rtm_pkg.sv =====
// Package for the range table block: item structs and command/status codes.
// No dependencies.
package rtm_pkg;

  localparam int FIELD_BITS = 48;
  localparam int COVER_BITS = 49;
  localparam int HIT_BITS   = 32;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REVERSED = 2'd2;

  typedef struct packed {
    logic [1:0]            command;
    logic [FIELD_BITS-1:0] range_low;
    logic [FIELD_BITS-1:0] range_high;
    logic [FIELD_BITS-1:0] query_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  hit;
    logic [HIT_BITS-1:0]   hit_total;
    logic [COVER_BITS-1:0] covered_total;
  } out_item_t;

endpackage

// ===== rtl/range_table_match_and_union_top.sv =====
// Range table: load, membership query with saturating hit count, union size, clear.
// Depends on rtm_pkg. Ranges live in one synchronous memory (start and end per entry).
//
//   channel  ports                      direction
//   in       in_valid in_ready in_data  item in
//   out      out_valid out_ready out_data  result item out
//
// Load and clear need no table scan. Query: one full scan of the stored ranges
// (one memory read a cycle). Report: repeated full scans; each merged
// run costs one scan to find it and one or more scans to extend it, plus a final scan
// that finds no further run.
// Reset clears the entry count, hit counter and all control; the memory is not cleared.
// One result register: the next item is taken while a result waits on out_ready.
module range_table_match_and_union_top #(
  parameter int MAX_RANGES = 256,
  parameter int VALUE_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rtm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rtm_pkg::out_item_t out_data
);
  import rtm_pkg::*;

  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int VB    = VALUE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QUERY = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_EXT   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]          state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [HIT_BITS-1:0] hits_r;
  logic [CNT_W-1:0]    idx_r;
  logic                rdv_r;
  logic [2*VB-1:0]     mem [MAX_RANGES];
  logic [2*VB-1:0]     rd_data_r;
  logic [VB-1:0]       qv_r;
  logic                found_r;
  logic                chg_r;
  logic [VB-1:0]       best_r;
  logic [VB-1:0]       hi_r;
  logic [VB:0]         pos_r;
  logic [VB:0]         total_r;
  out_item_t           res_r;
  out_item_t           out_data_r;
  logic                out_valid_r;

  logic [VB-1:0]       in_lo, in_hi, in_qv, rd_lo, rd_hi, cand;
  logic                accept, wr_en, rd_en, scan_done, emit_go;
  logic [1:0]          ld_status;
  logic [HIT_BITS-1:0] hits_q;

  assign in_lo  = VB'(in_data.range_low);
  assign in_hi  = VB'(in_data.range_high);
  assign in_qv  = VB'(in_data.query_value);
  assign rd_lo  = rd_data_r[2*VB-1:VB];
  assign rd_hi  = rd_data_r[VB-1:0];
  assign cand   = (rd_lo > VB'(pos_r)) ? rd_lo : VB'(pos_r);

  always_comb begin
    if (cnt_r == CNT_W'(MAX_RANGES)) begin
      ld_status = ST_FULL;
    end else if (in_lo > in_hi) begin
      ld_status = ST_REVERSED;
    end else begin
      ld_status = ST_OK;
    end
  end

  // saturating hit count after the current query
  assign hits_q = (found_r && hits_r != '1) ? hits_r + 1'b1 : hits_r;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign wr_en     = accept && (in_data.command == CMD_LOAD) && (ld_status == ST_OK);
  assign rd_en     = (state_r == S_QUERY || state_r == S_FIND || state_r == S_EXT) &&
                     (idx_r != cnt_r);
  assign scan_done = (idx_r == cnt_r) && !rdv_r;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= {in_lo, in_hi};
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hits_r      <= '0;
      idx_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      // shared table scan: one read issued a cycle, data registered and valid in the next cycle
      if (rd_en) begin
        idx_r <= idx_r + 1'b1;
        rdv_r <= 1'b1;
      end else begin
        rdv_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            idx_r   <= '0;
            found_r <= 1'b0;
            chg_r   <= 1'b0;
            pos_r   <= '0;
            total_r <= '0;
            qv_r    <= in_qv;
            case (in_data.command)
              CMD_LOAD: begin
                res_r   <= '{status: ld_status, hit: 1'b0, hit_total: hits_r,
                            covered_total: '0};
                if (ld_status == ST_OK) begin
                  cnt_r <= cnt_r + 1'b1;
                end
                state_r <= S_EMIT;
              end
              CMD_QUERY: begin
                res_r   <= '0;
                state_r <= S_QUERY;
              end
              CMD_REPORT: begin
                res_r   <= '0;
                state_r <= S_FIND;
              end
              CMD_CLEAR: begin
                res_r   <= '0;
                cnt_r   <= '0;
                hits_r  <= '0;
                state_r <= S_EMIT;
              end
              default: begin
                res_r   <= '0;
                state_r <= S_EMIT;
              end
            endcase
          end
        end
        S_QUERY: begin
          if (rdv_r && qv_r >= rd_lo && qv_r <= rd_hi) begin
            found_r <= 1'b1;
          end
          if (scan_done) begin
            res_r   <= '{status: ST_OK, hit: found_r, hit_total: hits_q, covered_total: '0};
            hits_r  <= hits_q;
            state_r <= S_EMIT;
          end
        end
        S_FIND: begin
          // lowest covered value at or above pos_r
          if (rdv_r && ((VB+1)'(rd_hi) >= pos_r)) begin
            if (!found_r || cand < best_r) begin
              best_r <= cand;
            end
            found_r <= 1'b1;
          end
          if (scan_done) begin
            if (!found_r) begin
              res_r   <= '{status: ST_OK, hit: 1'b0, hit_total: hits_r,
                          covered_total: COVER_BITS'(total_r)};
              state_r <= S_EMIT;
            end else begin
              hi_r    <= best_r;
              chg_r   <= 1'b0;
              idx_r   <= '0;
              state_r <= S_EXT;
            end
          end
        end
        S_EXT: begin
          // grow the run while any range starts inside it and ends beyond it
          if (rdv_r && rd_lo <= hi_r && rd_hi > hi_r) begin
            hi_r  <= rd_hi;
            chg_r <= 1'b1;
          end
          if (scan_done) begin
            idx_r <= '0;
            if (chg_r) begin
              chg_r <= 1'b0;
            end else begin
              total_r <= total_r + (VB+1)'(hi_r) - (VB+1)'(best_r) + 1'b1;
              pos_r   <= (VB+1)'(hi_r) + 1'b1;
              found_r <= 1'b0;
              state_r <= S_FIND;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RANGES)) else $error("entry count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE) else $error("item accepted without work");

  a_emit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !out_valid_r) |=> out_valid_r)
    else $error("result not presented");

endmodule

// ===== dv/range_table_match_and_union_checker.sv =====
// Checker for the range table: watches both channels, predicts each result item
// from the accepted commands and compares field by field. Depends on rtm_pkg.
module range_table_match_and_union_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rtm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rtm_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtm_pkg::*;

  localparam int EXP_DEPTH = 8;

  logic [FIELD_BITS-1:0] range_lo[TABLE_DEPTH];
  logic [FIELD_BITS-1:0] range_hi[TABLE_DEPTH];
  int                    range_count;
  logic [HIT_BITS-1:0]   hit_count;
  out_item_t             exp_buf[EXP_DEPTH];
  int                    exp_wr;
  int                    exp_rd;

  function automatic logic [COVER_BITS-1:0] union_length();
    logic [FIELD_BITS-1:0] sl[TABLE_DEPTH];
    logic [FIELD_BITS-1:0] sh[TABLE_DEPTH];
    logic [FIELD_BITS-1:0] run_lo, run_hi;
    logic [COVER_BITS-1:0] total;
    int j;
    total = '0;
    if (range_count == 0) return '0;
    // insertion sort on start; equal starts keep load order
    for (int i = 0; i < range_count; i++) begin
      j = i;
      while (j > 0 && sl[j-1] > range_lo[i]) begin
        sl[j] = sl[j-1];
        sh[j] = sh[j-1];
        j--;
      end
      sl[j] = range_lo[i];
      sh[j] = range_hi[i];
    end
    run_lo = sl[0];
    run_hi = sh[0];
    for (int i = 1; i < range_count; i++) begin
      if (sl[i] <= run_hi) begin
        if (sh[i] > run_hi) run_hi = sh[i];
      end else begin
        total += COVER_BITS'(run_hi - run_lo) + 1;
        run_lo = sl[i];
        run_hi = sh[i];
      end
    end
    total += COVER_BITS'(run_hi - run_lo) + 1;
    return total;
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.command)
      CMD_LOAD: begin
        if (range_count >= TABLE_DEPTH) r.status = ST_FULL;
        else if (it.range_low > it.range_high) r.status = ST_REVERSED;
        else begin
          range_lo[range_count] = it.range_low;
          range_hi[range_count] = it.range_high;
          range_count++;
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < range_count; i++)
          if (it.query_value >= range_lo[i] && it.query_value <= range_hi[i]) r.hit = 1'b1;
        if (r.hit && hit_count != '1) hit_count++;
      end
      CMD_REPORT: r.covered_total = union_length();
      CMD_CLEAR: begin
        range_count = 0;
        hit_count   = '0;
      end
      default: ;
    endcase
    r.hit_total = hit_count;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t pred;
    if (!rst_n) begin
      range_count = 0;
      hit_count   = '0;
      exp_wr      = 0;
      exp_rd      = 0;
      pending     = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending == 0) begin
          note_mismatch("result item with none expected", 64'(out_data.covered_total),
                        64'd0);
        end else begin
          want   = exp_buf[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_DEPTH;
          pending--;
          if (out_data.status !== want.status)
            note_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.hit !== want.hit)
            note_mismatch("hit", 64'(out_data.hit), 64'(want.hit));
          if (out_data.hit_total !== want.hit_total)
            note_mismatch("hit_total", 64'(out_data.hit_total), 64'(want.hit_total));
          if (out_data.covered_total !== want.covered_total)
            note_mismatch("covered_total", 64'(out_data.covered_total),
                          64'(want.covered_total));
        end
      end
      if (in_valid && in_ready) begin
        pred = apply_command(in_data);
        if (pending == EXP_DEPTH) begin
          note_mismatch("items in flight", 64'(pending), 64'(EXP_DEPTH));
        end else begin
          exp_buf[exp_wr] = pred;
          exp_wr = (exp_wr + 1) % EXP_DEPTH;
          pending++;
        end
      end
    end
  end

endmodule

// ===== dv/range_table_match_and_union_top_tb.sv =====
// Testbench top for the range table: clock, reset, command stimulus with bursty
// sending and a stalling receiver, verdict. Depends on rtm_pkg and the checker.
module range_table_match_and_union_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtm_pkg::*;

  localparam int  DEPTH      = 256;
  localparam int  ITEM_GOAL  = 1850;
  localparam int  CYCLE_LIMIT = 8000000;
  localparam logic [FIELD_BITS-1:0] VMAX = '1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count, pending;
  int        cycle_count = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        table_fill = 0;

  always #6 clk = ~clk;

  range_table_match_and_union_top #(.MAX_RANGES(DEPTH), .VALUE_BITS(FIELD_BITS)) u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  range_table_match_and_union_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("range_table_match_and_union_top: mismatch");
      $finish;
    end
  end

  // receiver: changing stall modes, plus two long hold-offs so the block backs up
  initial begin
    int cyc, hold, mode, mode_left;
    cyc = 0; hold = 0; mode = 0; mode_left = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 3000 || cyc == 60000) hold = 2500;
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [FIELD_BITS-1:0] rand_value();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return FIELD_BITS'($urandom_range(0, 300));
      5, 6:          return VMAX - FIELD_BITS'($urandom_range(0, 300));
      default:       return w[FIELD_BITS-1:0];
    endcase
  endfunction

  // called just after a rising edge; returns after the edge that took the item and any idle gap
  task automatic send(logic [1:0] cmd, logic [FIELD_BITS-1:0] lo, hi, qv);
    logic took;
    int gap;
    in_data  <= '{command: cmd, range_low: lo, range_high: hi, query_value: qv};
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
    if (cmd == CMD_CLEAR) table_fill = 0;
    else if (cmd == CMD_LOAD && table_fill < DEPTH && lo <= hi) table_fill++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      gap = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_random(int reversed_pct);
    logic [FIELD_BITS-1:0] a, b, t;
    a = rand_value();
    b = $urandom_range(0, 1) ? a + FIELD_BITS'($urandom_range(0, 40)) : rand_value();
    if (b < a && $urandom_range(0, 99) >= reversed_pct) begin
      t = a; a = b; b = t;
    end
    send(CMD_LOAD, a, b, rand_value());
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, reversed ranges, extremes, adjacent ranges, clear
    send(CMD_REPORT, 0, 0, 0);
    send(CMD_QUERY, 0, 0, 0);
    send(CMD_LOAD, VMAX, 0, VMAX);
    send(CMD_LOAD, 5, 4, 0);
    send(CMD_LOAD, 0, 0, 0);
    send(CMD_LOAD, VMAX, VMAX, 0);
    send(CMD_QUERY, VMAX, 0, 0);
    send(CMD_QUERY, 0, VMAX, 1);
    send(CMD_LOAD, 10, 19, 0);
    send(CMD_LOAD, 20, 29, 0);
    send(CMD_QUERY, 0, 0, 19);
    send(CMD_QUERY, 0, 0, 20);
    send(CMD_QUERY, 0, 0, 30);
    send(CMD_REPORT, VMAX, VMAX, VMAX);
    send(CMD_LOAD, 0, VMAX, 0);
    send(CMD_REPORT, 0, 0, 0);
    send(CMD_QUERY, 0, 0, VMAX - 1);
    send(CMD_CLEAR, VMAX, VMAX, VMAX);
    send(CMD_QUERY, 0, 0, 0);
    send(CMD_REPORT, 0, 0, 0);
    drain();

    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 199) == 0 || (items_sent > 900 && items_sent < 920)) begin
        // fill the table, then try more loads, some with reversed bounds
        drain();
        send(CMD_CLEAR, 0, 0, 0);
        while (table_fill < DEPTH) load_random(5);
        repeat (4) send(CMD_LOAD, rand_value(), rand_value(), 0);
        send(CMD_LOAD, VMAX, 0, 0);
        repeat (6) send(CMD_QUERY, 0, 0, rand_value());
        send(CMD_REPORT, 0, 0, 0);
        send(CMD_CLEAR, 0, 0, 0);
      end else if ($urandom_range(0, 9) == 0) begin
        send(2'($urandom_range(0, 3)), FIELD_BITS'({$urandom, $urandom}),
             FIELD_BITS'({$urandom, $urandom}), FIELD_BITS'({$urandom, $urandom}));
        if (table_fill > 40) send(CMD_CLEAR, 0, 0, 0);
      end else begin
        if (table_fill > 32 || $urandom_range(0, 9) < 7) send(CMD_CLEAR, 0, 0, 0);
        n = $urandom_range(1, 8);
        repeat (n) load_random(10);
        n = $urandom_range(1, 6);
        repeat (n) send(CMD_QUERY, rand_value(), rand_value(), rand_value());
        send(CMD_REPORT, rand_value(), rand_value(), rand_value());
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("range_table_match_and_union_top: match");
    end else begin
      $display("range_table_match_and_union_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rtm_pkg.sv
rtl/range_table_match_and_union_top.sv
dv/range_table_match_and_union_checker.sv
dv/range_table_match_and_union_top_tb.sv
